@@ design/utfs_pkg.sv @@
// Package for the UTF-8 character boundary segmenter.
// Holds byte-class constants, result field layout and the run record type.
// No dependencies.
package utfs_pkg;

  localparam int OFFSET_BITS = 16;

  // Result tdata layout, lowest bit first
  localparam int BYTE_LSB  = 0;
  localparam int OFS_LSB   = 8;
  localparam int OVF_BIT   = OFS_LSB + OFFSET_BITS;
  localparam int START_BIT = OVF_BIT + 1;
  localparam int LEN_LSB   = START_BIT + 1;
  localparam int DATA_BITS = LEN_LSB + 3;
  localparam int TDATA_W   = ((DATA_BITS + 7) / 8) * 8;

  localparam logic [7:0] TRAIL_LO = 8'h80;
  localparam logic [7:0] TRAIL_HI = 8'hBF;
  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  // Results caused by one input byte, released in order
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;     // 0..4 results
    logic            complete;  // bytes form one multi-byte character
    logic [2:0]      char_len;  // length for the first result
    logic            eot;       // run ends the text
  } run_t;

  // Full sequence length for a lead byte, 0 if not a lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
    else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
    else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
    return len;
  endfunction

endpackage

@@ design/utfs_segment.sv @@
// Sequence tracker: holds lead and trail bytes and builds the run of results
// for each accepted byte. Depends on utfs_pkg.
module utfs_segment import utfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output run_t       run
);

  logic [7:0] held_bytes [4];
  logic [2:0] held_count;
  logic [2:0] needed_length;

  logic       trail;
  logic [2:0] lead_len;
  logic       consume;
  logic [2:0] new_count;
  logic       complete;

  always_comb begin
    trail     = (data_byte >= TRAIL_LO) && (data_byte <= TRAIL_HI);
    lead_len  = lead_length(data_byte);
    consume   = (held_count != 3'd0) && trail;
    new_count = held_count + 3'd1;
    complete  = consume && (new_count >= needed_length);

    // Held bytes first, then the new byte
    for (int i = 0; i < 4; i++) begin
      run.bytes[i] = (3'(i) < held_count) ? held_bytes[i] : data_byte;
    end
    if (consume) begin
      run.count = (complete || end_of_text) ? new_count : 3'd0;
    end else begin
      run.count = (lead_len != 3'd0 && !end_of_text) ? held_count : new_count;
    end
    run.complete = complete;
    run.char_len = complete ? needed_length : 3'd1;
    run.eot      = end_of_text;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= 3'd0;
      needed_length <= 3'd0;
    end else if (accept) begin
      if (consume && !complete && !end_of_text) begin
        held_count <= new_count;
      end else if (!consume && lead_len != 3'd0 && !end_of_text) begin
        held_count    <= 3'd1;
        needed_length <= lead_len;
      end else begin
        held_count    <= 3'd0;
        needed_length <= 3'd0;
      end
    end
  end

  // Held byte store, no reset: only written entries are read
  always_ff @(posedge clk) begin
    if (accept) begin
      if (consume && !complete && !end_of_text) begin
        held_bytes[held_count[1:0]] <= data_byte;
      end else if (!consume && lead_len != 3'd0 && !end_of_text) begin
        held_bytes[0] <= data_byte;
      end
    end
  end

endmodule

@@ design/utfs_emit.sv @@
// Result stage (uses utfs_pkg): registers one run and releases its results
// one per cycle while m_tready is high, each with its saturating byte offset.
module utfs_emit import utfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               load,
  input  run_t               run_in,
  output logic               can_load,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast,
  output logic               m_tuser
);

  run_t                 run;
  logic                 run_valid;
  logic [1:0]           idx;
  logic [OFFSET_BITS:0] pos;

  logic                 last_item;
  logic                 take;
  logic                 char_start;
  logic [2:0]           char_length;
  logic [OFFSET_BITS-1:0] byte_offset;
  logic [DATA_BITS-1:0] packed_data;

  always_comb begin
    last_item   = ({1'b0, idx} == (run.count - 3'd1));
    take        = run_valid && m_tready;
    can_load    = !run_valid || (take && last_item);
    char_start  = !(run.complete && idx != 2'd0);
    char_length = (idx == 2'd0) ? run.char_len : 3'd1;
    byte_offset = pos[OFFSET_BITS] ? {OFFSET_BITS{1'b1}} : pos[OFFSET_BITS-1:0];
    packed_data = {char_length, char_start, pos[OFFSET_BITS], byte_offset,
                   run.bytes[idx]};
    m_tvalid    = run_valid;
    m_tdata     = TDATA_W'(packed_data);
    m_tuser     = last_item;
    m_tlast     = last_item && run.eot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (load) begin
      run_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (take && last_item) begin
      run_valid <= 1'b0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      run <= run_in;
    end
  end

  // Offset of the next result; restart after the final byte of a text
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      if (last_item && run.eot) begin
        pos <= '0;
      end else if (!pos[OFFSET_BITS]) begin
        pos <= pos + 1'b1;
      end
    end
  end

endmodule

@@ design/utf8_char_boundary_segmenter.sv @@
// Top level of the UTF-8 character boundary segmenter.
// Instantiates utfs_segment and utfs_emit; depends on utfs_pkg.
//
// Usage:
//   Input stream (s_*): one text byte per request. s_tdata carries the byte,
//   s_tlast marks the final byte of the text. A request is taken on a clock
//   edge with s_tvalid and s_tready both high.
//   Output stream (m_*): one result per byte, in the original byte order.
//   m_tdata reports the byte, its offset in the text (saturating, with an
//   overflow flag), whether a character starts there and its length.
//   m_tlast flags the result for the final byte of the text; m_tuser flags
//   the last result caused by one input request.
// Latency and throughput:
//   Results appear in the cycle after the request that releases them. A byte
//   that gives one result is taken every cycle while m_tready is high. A byte
//   whose run holds N results occupies the result register until its last result
//   is taken; a held lead or trail byte gives no result until its sequence completes or breaks.
// Reset: rst (synchronous) drops any held sequence, empties the result
//   register and sets the offset back to zero.
// Stall: the waiting result holds while m_tready is low. s_tready is low while
//   a result waits, except in a cycle where the last result of a run is taken.
module utf8_char_boundary_segmenter import utfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // data_byte
  input  logic               s_tlast,   // end_of_text
  output logic               m_tvalid,
  input  logic               m_tready,
  // m_tdata, low bit up: out_byte, byte_offset, offset_overflow,
  // char_start, char_length, zero fill
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast,   // text_done
  output logic               m_tuser    // last_of_run
);

  run_t run;
  logic accept;
  logic can_load;

  // Take a byte whenever the result register is free or frees this cycle
  assign s_tready = can_load;
  assign accept   = s_tvalid && s_tready;

  utfs_segment u_segment (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .data_byte   (s_tdata),
    .end_of_text (s_tlast),
    .run         (run)
  );

  // Load only runs that release something; held bytes leave the stage empty
  utfs_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (accept && (run.count != 3'd0)),
    .run_in   (run),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

@@ design/utfs_checker.sv @@
// Port-level checks for the UTF-8 character boundary segmenter, bound to the
// top level. Depends on utfs_pkg.
module utfs_checker import utfs_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast,
  input logic               m_tuser
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

  // Final byte of a text always closes its run
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tuser)
    else $error("text_done without last_of_run");

  // A run continues in the next cycle once a middle result is taken
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tuser |=> m_tvalid)
    else $error("run broken off");

  // Offsets count up by one inside a run
  a_offset: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tuser && !m_tdata[OVF_BIT] &&
    (m_tdata[OVF_BIT-1:OFS_LSB] != {OFFSET_BITS{1'b1}})
    |=> m_tdata[OVF_BIT-1:OFS_LSB] == $past(m_tdata[OVF_BIT-1:OFS_LSB]) + 1'b1)
    else $error("offset did not advance");

  // Nothing is offered right after reset
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind utf8_char_boundary_segmenter utfs_checker u_utfs_checker (.*);

@@ bench/utfs_boundary_checker.sv @@
// Result checker for the UTF-8 character boundary segmenter bench.
// Watches both streams, rebuilds the expected per-byte annotations and
// compares them; depends on utfs_pkg for widths, field layout and byte classes.
`timescale 1ns / 1ps

module utfs_boundary_checker import utfs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [7:0]         s_tdata,
  input  logic               s_tlast,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic               m_tlast,
  input  logic               m_tuser,
  output int                 errors,
  output int                 pending
);

  localparam logic [OFFSET_BITS:0] OFS_CAP = 1 << OFFSET_BITS;
  localparam logic [OFFSET_BITS:0] OFS_MAX = OFS_CAP - 1;

  typedef struct packed {
    logic [7:0]             ch_byte;
    logic [OFFSET_BITS-1:0] offset;
    logic                   ovf;
    logic                   start;
    logic [2:0]             len;
    logic                   done;
    logic                   run_end;
  } annot_t;

  annot_t annot_q[$];    // annotations still to come, oldest first
  annot_t step_annots[$];

  logic [3:0][7:0]        seq_bytes;
  int                     seq_cnt;
  int                     seq_len;
  logic [OFFSET_BITS:0]   next_pos;

  function automatic int seq_len_of(input logic [7:0] b);
    if (b inside {[LEAD2_LO:LEAD2_HI]}) return 2;
    if (b inside {[LEAD3_LO:LEAD3_HI]}) return 3;
    if (b inside {[LEAD4_LO:LEAD4_HI]}) return 4;
    return 0;
  endfunction

  task automatic release_byte(input logic [7:0] b, input logic start, input int len);
    annot_t a;
    a.ch_byte = b;
    a.offset  = (next_pos > OFS_MAX) ? OFS_MAX[OFFSET_BITS-1:0]
                                     : next_pos[OFFSET_BITS-1:0];
    a.ovf     = next_pos > OFS_MAX;
    a.start   = start;
    a.len     = 3'(len);
    a.done    = 1'b0;
    a.run_end = 1'b0;
    if (next_pos < OFS_CAP) next_pos++;
    step_annots.push_back(a);
  endtask

  task automatic flush_seq();
    for (int i = 0; i < seq_cnt; i++) release_byte(seq_bytes[i], 1'b1, 1);
    seq_cnt = 0;
    seq_len = 0;
  endtask

  task automatic segment_byte(input logic [7:0] b, input logic eot);
    bit taken;
    int len;
    taken = 0;
    step_annots.delete();
    if (seq_cnt > 0) begin
      if (b inside {[TRAIL_LO:TRAIL_HI]} && seq_cnt < 4) begin
        seq_bytes[seq_cnt] = b;
        seq_cnt++;
        taken = 1;
        if (seq_cnt >= seq_len) begin
          release_byte(seq_bytes[0], 1'b1, seq_len);
          for (int i = 1; i < seq_cnt; i++) release_byte(seq_bytes[i], 1'b0, 1);
          seq_cnt = 0;
          seq_len = 0;
        end else if (eot) begin
          flush_seq();
        end
      end else begin
        flush_seq();
      end
    end
    if (!taken) begin
      len = seq_len_of(b);
      if (len != 0) begin
        seq_bytes[0] = b;
        seq_cnt = 1;
        seq_len = len;
        if (eot) flush_seq();
      end else begin
        release_byte(b, 1'b1, 1);
      end
    end
    if (step_annots.size() > 0) begin
      step_annots[step_annots.size()-1].run_end = 1'b1;
      if (eot) step_annots[step_annots.size()-1].done = 1'b1;
    end
    foreach (step_annots[i]) annot_q.push_back(step_annots[i]);
    if (eot) begin
      seq_cnt  = 0;
      seq_len  = 0;
      next_pos = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s got 0x%0h, want 0x%0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic check_annot();
    annot_t w;
    if (annot_q.size() == 0) begin
      report_mismatch("result with nothing pending, out_byte", m_tdata[BYTE_LSB +: 8], 0);
      return;
    end
    w = annot_q.pop_front();
    if (m_tdata[BYTE_LSB +: 8] !== w.ch_byte)
      report_mismatch("out_byte", m_tdata[BYTE_LSB +: 8], w.ch_byte);
    if (m_tdata[OFS_LSB +: OFFSET_BITS] !== w.offset)
      report_mismatch("byte_offset", m_tdata[OFS_LSB +: OFFSET_BITS], w.offset);
    if (m_tdata[OVF_BIT] !== w.ovf)
      report_mismatch("offset_overflow", m_tdata[OVF_BIT], w.ovf);
    if (m_tdata[START_BIT] !== w.start)
      report_mismatch("char_start", m_tdata[START_BIT], w.start);
    if (m_tdata[LEN_LSB +: 3] !== w.len)
      report_mismatch("char_length", m_tdata[LEN_LSB +: 3], w.len);
    if (m_tlast !== w.done)
      report_mismatch("text_done", m_tlast, w.done);
    if (m_tuser !== w.run_end)
      report_mismatch("last_of_run", m_tuser, w.run_end);
  endtask

  initial begin
    errors   = 0;
    pending  = 0;
    seq_cnt  = 0;
    seq_len  = 0;
    next_pos = '0;
  end

  // Compare first: a result never belongs to a request taken at the same edge
  always @(posedge clk) begin
    if (rst) begin
      annot_q.delete();
      seq_cnt  = 0;
      seq_len  = 0;
      next_pos = '0;
    end else begin
      if (m_tvalid && m_tready) check_annot();
      if (s_tvalid && s_tready) segment_byte(s_tdata, s_tlast);
    end
    pending = annot_q.size();
  end

endmodule

@@ bench/utf8_char_boundary_segmenter_tb.sv @@
// Top of the UTF-8 character boundary segmenter bench: clock, reset, stimulus
// and verdict. Depends on utfs_pkg, the segmenter RTL and utfs_boundary_checker.
`timescale 1ns / 1ps

module utf8_char_boundary_segmenter_tb;
  import utfs_pkg::*;

  localparam int PHASE_BYTES = 52;

  // Directed bytes, bit 8 marks the final byte of a text
  localparam logic [8:0] DIRECTED [24] = '{
    9'h000, 9'h07F,                     // ASCII extremes
    9'h0C2, 9'h080, 9'h0DF, 9'h0BF,     // two-byte, both ends of the lead range
    9'h0E0, 9'h080, 9'h080,             // three-byte
    9'h0F0, 9'h080, 9'h080, 9'h080,     // four-byte, lowest lead
    9'h0F4, 9'h0BF, 9'h0BF, 9'h0BF,     // four-byte, highest lead, highest trail
    9'h0C2, 9'h041,                     // broken sequence
    9'h0FF, 9'h080,                     // invalid byte, stray trail
    9'h1E0,                             // text ends on a lead
    9'h0F0, 9'h190                      // text ends mid-sequence
  };

  logic               clk;
  logic               rst;
  logic               s_tvalid;
  logic               s_tready;
  logic [7:0]         s_tdata;
  logic               s_tlast;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;
  logic               m_tuser;

  int                 errors;
  int                 pending;
  int                 send_idle_pct;
  int                 recv_stall_pct;
  logic [7:0]         text_q[$];

  utf8_char_boundary_segmenter i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  utfs_boundary_checker i_checker (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .errors   (errors),
    .pending  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random, decided at each falling edge
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offer one request; called and left at a falling edge. Valid is set once
  // per step, so a back-to-back request keeps it high without a glitch.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  // Hold the sender until every annotation has come back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Append one character: mostly well formed, some truncated, some noise
  task automatic add_char();
    int pick;
    int n_trail;
    int n_sent;
    pick = $urandom_range(99);
    if (pick < 40) begin
      text_q.push_back(8'($urandom_range(8'h7F)));
    end else if (pick < 90) begin
      n_trail = $urandom_range(3, 1);
      case (n_trail)
        1: text_q.push_back(8'($urandom_range(LEAD2_HI, LEAD2_LO)));
        2: text_q.push_back(8'($urandom_range(LEAD3_HI, LEAD3_LO)));
        default: text_q.push_back(8'($urandom_range(LEAD4_HI, LEAD4_LO)));
      endcase
      n_sent = (pick < 82) ? n_trail : $urandom_range(n_trail - 1);
      repeat (n_sent) text_q.push_back(8'($urandom_range(TRAIL_HI, TRAIL_LO)));
    end else begin
      text_q.push_back(8'($urandom_range(255)));
    end
  endtask

  // Send the built text, flag its final byte, then empty the buffer
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  initial begin
    int n_chars;
    int sent;
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, full rate both sides
    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    drain();

    // Random texts under each idling pattern
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      sent = 0;
      while (sent < PHASE_BYTES) begin
        n_chars = $urandom_range(8, 1);
        repeat (n_chars) add_char();
        sent += text_q.size();
        send_text();
      end
      drain();
    end

    // Let any stray result show up before the verdict
    repeat (10) @(negedge clk);
    if (errors == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin
    #1_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
